>>> sv/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types, constants and codes of the sorted minimum priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

	localparam int DEPTH   = 16;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int VALUE_W = 32;
	localparam int CAP_W   = 5;
	localparam int COUNT_W = 5;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic [CAP_W-1:0]          cap_t;
	typedef logic [COUNT_W-1:0]        count_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	localparam cap_t CAP_RESET = cap_t'(16);

	// Per-cycle command broadcast to every cell of the row.
	typedef struct packed {
		logic   ins;
		logic   rem;
		value_t x;
	} cell_ctrl_t;

endpackage

>>> sv/smpq_if.sv
// ----------------------------------------------------------------------------
// smpq_if
// Channel interfaces of the queue: request, response and capacity write.
// ----------------------------------------------------------------------------
interface smpq_req_if;
	import smpq_pkg::*;
	logic   valid;
	logic   ready;
	op_t    operation;
	value_t value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

interface smpq_rsp_if;
	import smpq_pkg::*;
	logic    valid;
	logic    ready;
	value_t  removed_value;
	status_t status;
	count_t  count;

	modport source (output valid, output removed_value, output status, output count,
		input ready);
	modport sink   (input valid, input removed_value, input status, input count,
		output ready);
endinterface

interface smpq_cfg_if;
	import smpq_pkg::*;
	logic valid;
	logic ready;
	cap_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> sv/smpq_cell.sv
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted row: compares against the incoming value and takes
// the incoming value, its own, its left or its right neighbor's value.
// ----------------------------------------------------------------------------
module smpq_cell (
	input  logic                 clk,
	input  smpq_pkg::cell_ctrl_t ctrl,
	input  logic                 valid,
	input  logic                 gt_left,
	input  smpq_pkg::value_t     left_data,
	input  smpq_pkg::value_t     right_data,
	output smpq_pkg::value_t     data,
	output logic                 gt
);
	import smpq_pkg::*;

	value_t data_q;

	assign data = data_q;
	assign gt   = valid && (data_q > ctrl.x);

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			// shift up behind the insert point, drop the new value at it
			if (gt_left) begin
				data_q <= left_data;
			end else if (gt || !valid) begin
				data_q <= ctrl.x;
			end
		end else if (ctrl.rem) begin
			data_q <= right_data;
		end
	end

endmodule

>>> sv/sorted_min_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Sorted priority queue of signed 32-bit values, smallest out first.
// ----------------------------------------------------------------------------
// The queue takes one request per clock and returns its response from an
// output register on the next clock; a request is taken while a response is
// still waiting as long as that response leaves at the same edge. The values
// live in a row of DEPTH cells kept in ascending order, cell 0 holding the
// smallest. On an insert every cell compares its value against the new one in
// parallel, so the row itself sets the single-cycle rate; a remove shifts the
// whole row down by one. Equal values leave oldest first. No clearing pass is
// needed after reset: the count marks which cells hold data.
module sorted_min_priority_queue (
	input  logic            clk,
	input  logic            arst_n,
	smpq_req_if.sink        req,
	smpq_rsp_if.source      rsp,
	smpq_cfg_if.sink        cfg
);
	import smpq_pkg::*;

	cap_t       capacity_q;
	cnt_t       count_q;
	logic       rsp_valid_q;
	value_t     removed_q;
	status_t    status_q;
	count_t     rsp_count_q;

	logic       accept;
	logic       full;
	logic       empty;
	cell_ctrl_t ctrl;
	cnt_t       count_next;
	status_t    status_next;

	value_t     cell_data [DEPTH];
	logic       cell_gt   [DEPTH];
	logic       cell_valid[DEPTH];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg.valid) begin
			capacity_q <= cfg.data;
		end
	end

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	// capacity above the built depth saturates through the second term
	assign full  = (32'(count_q) >= 32'(capacity_q)) || (count_q == cnt_t'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		ctrl.x      = req.value;
		ctrl.ins    = 1'b0;
		ctrl.rem    = 1'b0;
		count_next  = count_q;
		status_next = ST_OK;
		case (req.operation)
			OP_INSERT: begin
				if (full) begin
					status_next = ST_OVERFLOW;
				end else begin
					ctrl.ins   = accept;
					count_next = count_q + cnt_t'(1);
				end
			end
			OP_REMOVE: begin
				if (empty) begin
					status_next = ST_UNDERFLOW;
				end else begin
					ctrl.rem   = accept;
					count_next = count_q - cnt_t'(1);
				end
			end
			default: begin
				status_next = ST_OK;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign cell_valid[i] = cnt_t'(i) < count_q;

		smpq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.valid      (cell_valid[i]),
			.gt_left    ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
			.left_data  (cell_data[(i == 0) ? 0 : i - 1]),
			.right_data (cell_data[(i == DEPTH - 1) ? i : i + 1]),
			.data       (cell_data[i]),
			.gt         (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			removed_q   <= (ctrl.rem) ? cell_data[0] : '0;
			status_q    <= status_next;
			rsp_count_q <= count_t'(count_next);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.removed_value = removed_q;
	assign rsp.status        = status_q;
	assign rsp.count         = rsp_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(DEPTH))
		else $error("count exceeds depth");

	a_row_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= cnt_t'(2)) |-> (cell_data[0] <= cell_data[1]))
		else $error("smallest cells out of order");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ctrl.ins) |=> (count_q == $past(count_q) + cnt_t'(1)))
		else $error("insert did not grow the count");

	a_underflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.operation == OP_REMOVE) && empty) |=>
			(rsp_valid_q && (removed_q == '0) && (status_q == ST_UNDERFLOW)))
		else $error("underflow response malformed");

endmodule
